// ----- rtl/core/ndef_pkg.sv -----
// Package for the NDEF record stream parser: section codes, field widths,
// and the helper that picks the first non-empty body field. No dependencies.
package ndef_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 32;
   localparam int SEC_W  = 3;
   localparam int IDX_W  = 2;

   // Section codes, also used as the parser phase
   localparam logic [SEC_W-1:0] SEC_HEADER  = 3'd0;
   localparam logic [SEC_W-1:0] SEC_TYPELEN = 3'd1;
   localparam logic [SEC_W-1:0] SEC_PAYLEN  = 3'd2;
   localparam logic [SEC_W-1:0] SEC_IDLEN   = 3'd3;
   localparam logic [SEC_W-1:0] SEC_TYPE    = 3'd4;
   localparam logic [SEC_W-1:0] SEC_ID      = 3'd5;
   localparam logic [SEC_W-1:0] SEC_PAYLOAD = 3'd6;

   // Index of the final byte of a long payload length
   localparam logic [IDX_W-1:0] LONG_LEN_LAST_IDX = 2'd3;

   // Header flag bit positions
   localparam int HDR_MB = 7;
   localparam int HDR_ME = 6;
   localparam int HDR_CF = 5;
   localparam int HDR_SR = 4;
   localparam int HDR_IL = 3;

   typedef struct packed {
      logic [SEC_W-1:0] phase;
      logic [LEN_W-1:0] remaining;
      logic             last;
   } body_type;

   // Enter the first non-empty body field at or after from_sec; flag the
   // record end when none is left.
   function automatic body_type enter_body(input logic [SEC_W-1:0]  from_sec,
                                           input logic [BYTE_W-1:0] type_cnt,
                                           input logic [BYTE_W-1:0] ident_cnt,
                                           input logic [LEN_W-1:0]  payload_cnt);
      body_type res;
      res.phase     = SEC_HEADER;
      res.remaining = '0;
      res.last      = 1'b1;
      if (from_sec <= SEC_TYPE && type_cnt != '0) begin
         res.phase     = SEC_TYPE;
         res.remaining = {{(LEN_W-BYTE_W){1'b0}}, type_cnt};
         res.last      = 1'b0;
      end else if (from_sec <= SEC_ID && ident_cnt != '0) begin
         res.phase     = SEC_ID;
         res.remaining = {{(LEN_W-BYTE_W){1'b0}}, ident_cnt};
         res.last      = 1'b0;
      end else if (from_sec <= SEC_PAYLOAD && payload_cnt != '0) begin
         res.phase     = SEC_PAYLOAD;
         res.remaining = payload_cnt;
         res.last      = 1'b0;
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/ndef_record_stream_parser_core.sv -----
// NDEF record stream parser top level: tags each byte with its section.
// Depends on ndef_pkg.
//
// Output: an accepted byte is registered and shows on the rsp_ ports in the following cycle.
// Throughput: one item per cycle; the output register accepts a new item whenever it is
// empty or being drained in the same cycle.
// Reset (synchronous, active high): parser waits for a header byte, all lengths and
// counters clear, no result is pending.
module ndef_record_stream_parser_core
   import ndef_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_byte_out,
   output logic [SEC_W-1:0]  rsp_section,
   output logic              rsp_record_last,
   output logic              rsp_flag_mb,
   output logic              rsp_flag_me,
   output logic              rsp_flag_cf,
   output logic              rsp_flag_sr,
   output logic              rsp_flag_il,
   output logic [2:0]        rsp_name_format,
   output logic [BYTE_W-1:0] rsp_type_len,
   output logic [BYTE_W-1:0] rsp_ident_len,
   output logic [LEN_W-1:0]  rsp_payload_len
);

   // Parser state
   logic [SEC_W-1:0]  phase_ff,       phase_in;
   logic [BYTE_W-1:0] header_ff,      header_in;
   logic [BYTE_W-1:0] type_cnt_ff,    type_cnt_in;
   logic [BYTE_W-1:0] ident_cnt_ff,   ident_cnt_in;
   logic [LEN_W-1:0]  payload_cnt_ff, payload_cnt_in;
   logic [LEN_W-1:0]  remaining_ff,   remaining_in;
   logic [IDX_W-1:0]  len_idx_ff,     len_idx_in;

   // Result register
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [SEC_W-1:0]  rsp_section_ff, section_in;
   logic              rsp_last_ff,    last_in;
   logic [BYTE_W-1:0] rsp_header_ff;
   logic [BYTE_W-1:0] rsp_type_len_ff;
   logic [BYTE_W-1:0] rsp_ident_len_ff;
   logic [LEN_W-1:0]  rsp_payload_len_ff;

   logic              accept;
   logic              len_done;
   logic [LEN_W-1:0]  payload_shift;
   body_type          body;

   // Take a new item when the result register is empty or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Long length: shift the new big-endian byte in
   assign payload_shift = {payload_cnt_ff[LEN_W-BYTE_W-1:0], req_data_byte};

   always_comb begin
      phase_in       = phase_ff;
      header_in      = header_ff;
      type_cnt_in    = type_cnt_ff;
      ident_cnt_in   = ident_cnt_ff;
      payload_cnt_in = payload_cnt_ff;
      remaining_in   = remaining_ff;
      len_idx_in     = len_idx_ff;
      section_in     = phase_ff;
      last_in        = 1'b0;
      len_done       = 1'b0;
      body           = '0;

      case (phase_ff)
         SEC_TYPELEN: begin
            type_cnt_in    = req_data_byte;
            len_idx_in     = '0;
            payload_cnt_in = '0;
            phase_in       = SEC_PAYLEN;
         end
         SEC_PAYLEN: begin
            if (header_ff[HDR_SR]) begin
               payload_cnt_in = {{(LEN_W-BYTE_W){1'b0}}, req_data_byte};
               len_done       = 1'b1;
            end else begin
               payload_cnt_in = payload_shift;
               len_done       = (len_idx_ff == LONG_LEN_LAST_IDX);
               len_idx_in     = len_idx_ff + 1'b1;
            end
            if (len_done) begin
               len_idx_in = '0;
               if (header_ff[HDR_IL]) begin
                  phase_in = SEC_IDLEN;
               end else begin
                  body         = enter_body(SEC_TYPE, type_cnt_ff, ident_cnt_ff,
                                            payload_cnt_in);
                  phase_in     = body.phase;
                  remaining_in = body.remaining;
                  last_in      = body.last;
               end
            end
         end
         SEC_IDLEN: begin
            ident_cnt_in = req_data_byte;
            body         = enter_body(SEC_TYPE, type_cnt_ff, req_data_byte, payload_cnt_ff);
            phase_in     = body.phase;
            remaining_in = body.remaining;
            last_in      = body.last;
         end
         SEC_TYPE, SEC_ID, SEC_PAYLOAD: begin
            if (remaining_ff > 32'd1) begin
               remaining_in = remaining_ff - 1'b1;
            end else begin
               // Field done: advance to the next non-empty field or end the record
               body         = enter_body(phase_ff + 1'b1, type_cnt_ff, ident_cnt_ff,
                                         payload_cnt_ff);
               phase_in     = body.phase;
               remaining_in = body.remaining;
               last_in      = body.last;
            end
         end
         default: begin
            // Header byte, also the fallback for the unused phase code
            section_in     = SEC_HEADER;
            header_in      = req_data_byte;
            type_cnt_in    = '0;
            ident_cnt_in   = '0;
            payload_cnt_in = '0;
            remaining_in   = '0;
            len_idx_in     = '0;
            phase_in       = SEC_TYPELEN;
         end
      endcase
   end

   // Advance parser state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= SEC_HEADER;
         header_ff      <= '0;
         type_cnt_ff    <= '0;
         ident_cnt_ff   <= '0;
         payload_cnt_ff <= '0;
         remaining_ff   <= '0;
         len_idx_ff     <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         header_ff      <= header_in;
         type_cnt_ff    <= type_cnt_in;
         ident_cnt_ff   <= ident_cnt_in;
         payload_cnt_ff <= payload_cnt_in;
         remaining_ff   <= remaining_in;
         len_idx_ff     <= len_idx_in;
      end
   end

   // Result valid: set on accept, drop when taken without a new item behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload: fields reflect state after the byte is taken in
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff        <= req_data_byte;
         rsp_section_ff     <= section_in;
         rsp_last_ff        <= last_in;
         rsp_header_ff      <= header_in;
         rsp_type_len_ff    <= type_cnt_in;
         rsp_ident_len_ff   <= ident_cnt_in;
         rsp_payload_len_ff <= payload_cnt_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_out    = rsp_byte_ff;
   assign rsp_section     = rsp_section_ff;
   assign rsp_record_last = rsp_last_ff;
   assign rsp_flag_mb     = rsp_header_ff[HDR_MB];
   assign rsp_flag_me     = rsp_header_ff[HDR_ME];
   assign rsp_flag_cf     = rsp_header_ff[HDR_CF];
   assign rsp_flag_sr     = rsp_header_ff[HDR_SR];
   assign rsp_flag_il     = rsp_header_ff[HDR_IL];
   assign rsp_name_format = rsp_header_ff[2:0];
   assign rsp_type_len    = rsp_type_len_ff;
   assign rsp_ident_len   = rsp_ident_len_ff;
   assign rsp_payload_len = rsp_payload_len_ff;

endmodule
